// ===== src/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// a implies b on the same clock edge
`define AST_IMP(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");
// a implies b on the next clock edge
`define AST_NXT(lbl, clk, rst_n, a, b) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");
`endif

// ===== src/tbt_pkg.sv =====
// package: types, constants and codes of the token bucket table
`default_nettype none
package tbt_pkg;
    localparam int NumBuckets = 1024;
    localparam int IdW = (NumBuckets > 1) ? $clog2(NumBuckets) : 1;
    localparam int CntW = $clog2(NumBuckets + 1);

    localparam logic [2:0] FN_CREATE  = 3'd0;
    localparam logic [2:0] FN_FETCH   = 3'd1;
    localparam logic [2:0] FN_RETURN  = 3'd2;
    localparam logic [2:0] FN_DESTROY = 3'd3;
    localparam logic [2:0] FN_TICK    = 3'd4;
    localparam logic [2:0] FN_CLEAR   = 3'd5;

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_ARG   = 3'd1;
    localparam logic [2:0] ST_NO_SLOT   = 3'd2;
    localparam logic [2:0] ST_NO_BUCKET = 3'd3;
    localparam logic [2:0] ST_EMPTY     = 3'd4;

    typedef struct packed {
        logic [2:0]  func;
        logic [9:0]  bucket_id;
        logic [15:0] amount;
        logic [15:0] rate;
        logic [15:0] capacity;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [9:0]  handle;
        logic [15:0] granted;
    } t_rsp;

    // classified command handed from front to back
    typedef enum logic [2:0] {
        OP_RESP = 3'd0,   // answer only
        OP_CREATE = 3'd1,
        OP_FETCH = 3'd2,
        OP_RETURN = 3'd3,
        OP_TICK = 3'd4
    } t_op;

    typedef struct packed {
        t_op            op;
        logic [IdW-1:0] slot;
        logic [15:0]    amount;
        logic [15:0]    rate;
        logic [15:0]    capacity;
        logic [2:0]     status;
        logic [9:0]     handle;
    } t_cmd;
endpackage
`default_nettype wire

// ===== src/tbt_front.sv =====
// front: liveness bits, argument checks, slot claim, command queue writes
`default_nettype none
module tbt_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire tbt_pkg::t_req  i_req,
    input  wire logic           i_q_full,
    input  wire logic           i_back_idle,
    output logic                o_busy,
    output logic                o_q_push,
    output tbt_pkg::t_cmd       o_q_cmd
);
    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SCAN  = 5'b00010,
        S_PUSH  = 5'b00100,
        S_CLEAR = 5'b01000,
        S_INIT  = 5'b10000
    } t_fst;

    t_fst r_st, n_st;
    logic r_live [tbt_pkg::NumBuckets];
    logic r_live_rd;
    logic [tbt_pkg::CntW-1:0] r_idx, n_idx;
    tbt_pkg::t_req r_req;
    tbt_pkg::t_cmd r_cmd, n_cmd;
    logic [tbt_pkg::IdW-1:0] w_id;
    logic [tbt_pkg::IdW-1:0] w_rd_addr;
    logic w_inrange;
    logic w_accept;
    logic w_last;
    logic w_live_we;
    logic w_live_wd;
    logic [tbt_pkg::IdW-1:0] w_live_wa;

    assign w_accept = i_start && !o_busy;
    assign w_id = r_req.bucket_id[tbt_pkg::IdW-1:0];
    assign w_inrange = ({22'd0, r_req.bucket_id} < 32'(tbt_pkg::NumBuckets));
    // live bit for the next index is read ahead, so it is ready when r_idx reaches it
    assign w_rd_addr = n_idx[tbt_pkg::IdW-1:0];
    assign w_last = (r_idx == tbt_pkg::CntW'(tbt_pkg::NumBuckets - 1));
    // a tick must not race a queued command on the same slot; wait for back
    assign o_busy = (r_st != S_IDLE);

    always_comb begin
        n_st = r_st;
        n_idx = r_idx;
        n_cmd = r_cmd;
        o_q_push = 1'b0;
        w_live_we = 1'b0;
        w_live_wd = 1'b0;
        w_live_wa = r_idx[tbt_pkg::IdW-1:0];
        case (r_st)
            S_IDLE: begin
                if (w_accept) begin
                    n_st = S_SCAN;
                    if (i_req.func == tbt_pkg::FN_CREATE) begin
                        n_idx = '0;
                    end else begin
                        n_idx = tbt_pkg::CntW'(i_req.bucket_id);
                    end
                end
            end
            S_SCAN: begin
                n_cmd.op = tbt_pkg::OP_RESP;
                n_cmd.slot = w_id;
                n_cmd.amount = r_req.amount;
                n_cmd.rate = r_req.rate;
                n_cmd.capacity = r_req.capacity;
                n_cmd.status = tbt_pkg::ST_OK;
                n_cmd.handle = '0;
                n_st = S_PUSH;
                case (r_req.func)
                    tbt_pkg::FN_CREATE: begin
                        if (r_req.rate == '0 || r_req.capacity == '0) begin
                            n_cmd.status = tbt_pkg::ST_BAD_ARG;
                        end else if (r_idx == tbt_pkg::CntW'(tbt_pkg::NumBuckets)) begin
                            n_cmd.status = tbt_pkg::ST_NO_SLOT;
                        end else if (!r_live_rd) begin
                            n_cmd.op = tbt_pkg::OP_CREATE;
                            n_cmd.slot = r_idx[tbt_pkg::IdW-1:0];
                            n_cmd.handle = 10'(r_idx);
                            w_live_we = 1'b1;
                            w_live_wd = 1'b1;
                        end else begin
                            n_idx = r_idx + 1'b1;
                            n_st = S_SCAN;
                        end
                    end
                    tbt_pkg::FN_FETCH, tbt_pkg::FN_RETURN: begin
                        if (!w_inrange || r_req.amount == '0) begin
                            n_cmd.status = tbt_pkg::ST_BAD_ARG;
                        end else if (!r_live_rd) begin
                            n_cmd.status = tbt_pkg::ST_NO_BUCKET;
                        end else begin
                            n_cmd.op = (r_req.func == tbt_pkg::FN_FETCH) ?
                                tbt_pkg::OP_FETCH : tbt_pkg::OP_RETURN;
                        end
                    end
                    tbt_pkg::FN_DESTROY: begin
                        if (!w_inrange) begin
                            n_cmd.status = tbt_pkg::ST_BAD_ARG;
                        end else if (!r_live_rd) begin
                            n_cmd.status = tbt_pkg::ST_NO_BUCKET;
                        end else begin
                            w_live_we = 1'b1;
                            w_live_wa = w_id;
                        end
                    end
                    tbt_pkg::FN_TICK: begin
                        n_cmd.op = tbt_pkg::OP_TICK;
                    end
                    tbt_pkg::FN_CLEAR: begin
                        n_st = S_CLEAR;
                        n_idx = '0;
                    end
                    default: begin
                        n_cmd.status = tbt_pkg::ST_BAD_ARG;
                    end
                endcase
            end
            S_CLEAR, S_INIT: begin
                // one live bit cleared per cycle
                w_live_we = 1'b1;
                if (w_last) begin
                    n_st = (r_st == S_INIT) ? S_IDLE : S_PUSH;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_PUSH: begin
                if (!i_q_full && (r_cmd.op != tbt_pkg::OP_TICK || i_back_idle)) begin
                    o_q_push = 1'b1;
                    n_st = S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_idx <= '0;
        end else begin
            r_st <= n_st;
            r_idx <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_req;
        end
        r_cmd <= n_cmd;
    end

    // live bit memory: one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_live_we) begin
            r_live[w_live_wa] <= w_live_wd;
        end
        r_live_rd <= r_live[w_rd_addr];
    end

    assign o_q_cmd = r_cmd;
endmodule
`default_nettype wire

// ===== src/tbt_queue.sv =====
// two-entry command queue between front and back
`default_nettype none
module tbt_queue (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire tbt_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output logic               o_full,
    output logic               o_empty,
    output tbt_pkg::t_cmd      o_cmd
);
    tbt_pkg::t_cmd r_mem [2];
    logic r_wp, r_rp;
    logic [1:0] r_cnt;

    assign o_full = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_cmd = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_cnt <= '0;
        end else begin
            if (i_push) r_wp <= ~r_wp;
            if (i_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, i_push} - {1'b0, i_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) r_mem[r_wp] <= i_cmd;
    end
endmodule
`default_nettype wire

// ===== src/tbt_back.sv =====
// back: bucket memory read-modify-write, tick sweep, result strobe
`default_nettype none
module tbt_back (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_q_empty,
    input  wire tbt_pkg::t_cmd i_cmd,
    output logic               o_pop,
    output logic               o_idle,
    output logic               o_done,
    output tbt_pkg::t_rsp      o_rsp
);
    typedef enum logic [3:0] {
        B_IDLE  = 4'b0001,
        B_READ  = 4'b0010,
        B_WRITE = 4'b0100,
        B_TICK  = 4'b1000
    } t_bst;

    t_bst r_st;
    tbt_pkg::t_cmd r_cmd;
    logic [15:0] r_tok [tbt_pkg::NumBuckets];
    logic [15:0] r_rate [tbt_pkg::NumBuckets];
    logic [15:0] r_cap [tbt_pkg::NumBuckets];
    logic [15:0] r_rd_tok, r_rd_rate, r_rd_cap;
    logic [tbt_pkg::IdW-1:0] r_addr;
    logic r_tick_wr;      // tick sweep: data for r_addr-1 is valid
    logic [tbt_pkg::IdW-1:0] r_wr_addr;
    logic [16:0] w_sum, w_tsum;
    logic [15:0] w_new, w_tnew, w_grant;

    assign o_idle = (r_st == B_IDLE) && i_q_empty;
    assign o_pop = (r_st == B_IDLE) && !i_q_empty;
    assign w_sum = {1'b0, r_rd_tok} + {1'b0, r_cmd.amount};
    assign w_new = (w_sum > {1'b0, r_rd_cap}) ? r_rd_cap : w_sum[15:0];
    assign w_tsum = {1'b0, r_rd_tok} + {1'b0, r_rd_rate};
    assign w_tnew = (w_tsum > {1'b0, r_rd_cap}) ? r_rd_cap : w_tsum[15:0];
    assign w_grant = (r_rd_tok <= r_cmd.amount) ? r_rd_tok : r_cmd.amount;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= B_IDLE;
            o_done <= 1'b0;
            r_tick_wr <= 1'b0;
        end else begin
            o_done <= 1'b0;
            case (r_st)
                B_IDLE: begin
                    if (!i_q_empty) begin
                        case (i_cmd.op)
                            tbt_pkg::OP_FETCH, tbt_pkg::OP_RETURN: r_st <= B_READ;
                            tbt_pkg::OP_TICK: r_st <= B_TICK;
                            default: o_done <= 1'b1;
                        endcase
                        r_tick_wr <= 1'b0;
                    end
                end
                B_READ: r_st <= B_WRITE;
                B_WRITE: begin
                    r_st <= B_IDLE;
                    o_done <= 1'b1;
                end
                B_TICK: begin
                    r_tick_wr <= 1'b1;
                    if (r_tick_wr && r_wr_addr == tbt_pkg::IdW'(tbt_pkg::NumBuckets - 1)) begin
                        r_st <= B_IDLE;
                        o_done <= 1'b1;
                    end
                end
                default: r_st <= B_IDLE;
            endcase
        end
    end

    // memory read port, registered data
    always_ff @(posedge i_clk) begin
        if (r_st == B_IDLE) begin
            r_cmd <= i_cmd;
            r_addr <= (i_cmd.op == tbt_pkg::OP_TICK) ? '0 : i_cmd.slot;
        end else if (r_st == B_TICK) begin
            r_addr <= r_addr + 1'b1;
        end
        r_wr_addr <= r_addr;
        r_rd_tok <= r_tok[r_addr];
        r_rd_rate <= r_rate[r_addr];
        r_rd_cap <= r_cap[r_addr];
    end

    // memory write port
    // the tick sweeps dead slots too: create zeroes tokens before a slot is read again
    always_ff @(posedge i_clk) begin
        if (r_st == B_IDLE && !i_q_empty && i_cmd.op == tbt_pkg::OP_CREATE) begin
            r_tok[i_cmd.slot] <= '0;
            r_rate[i_cmd.slot] <= i_cmd.rate;
            r_cap[i_cmd.slot] <= i_cmd.capacity;
        end else if (r_st == B_WRITE && r_cmd.op == tbt_pkg::OP_FETCH) begin
            r_tok[r_cmd.slot] <= r_rd_tok - w_grant;
        end else if (r_st == B_WRITE) begin
            r_tok[r_cmd.slot] <= w_new;
        end else if (r_st == B_TICK && r_tick_wr) begin
            r_tok[r_wr_addr] <= w_tnew;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (r_st == B_IDLE) begin
            o_rsp.status <= i_cmd.status;
            o_rsp.handle <= i_cmd.handle;
            o_rsp.granted <= '0;
        end else if (r_st == B_WRITE && r_cmd.op == tbt_pkg::OP_FETCH) begin
            o_rsp.status <= (r_rd_tok == '0) ? tbt_pkg::ST_EMPTY : tbt_pkg::ST_OK;
            o_rsp.granted <= w_grant;
        end
    end
endmodule
`default_nettype wire

// ===== src/token_bucket_table.sv =====
// top level: token bucket table with decoupled front, queue and back
// done strobe: destroy and rejected items from back idle; fetch/return via B_READ, B_WRITE
// create: the front scans live bits from slot 0 up to the first free one, or all when full
// tick sweeps all bucket entries, clear-all all live bits; both sweep one entry per cycle
// one item at a time, the next taken once r_pend clears after the strobe; no result stall
// reset: synchronous active low, then busy for a pass clearing all live bits
`default_nettype none
module token_bucket_table (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire tbt_pkg::t_req i_req,
    output logic               o_busy,
    output logic               o_done,
    output tbt_pkg::t_rsp      o_rsp
);
    logic w_push, w_pop, w_full, w_empty, w_back_idle, w_fbusy;
    tbt_pkg::t_cmd w_fcmd, w_qcmd;
    logic r_pend;   // an item is accepted and its result not yet shown

    // front: classification and live bits
    tbt_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(i_start && !r_pend),
        .i_req(i_req), .i_q_full(w_full), .i_back_idle(w_back_idle),
        .o_busy(w_fbusy), .o_q_push(w_push), .o_q_cmd(w_fcmd)
    );

    // short queue parts front and back
    tbt_queue u_queue (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_push(w_push), .i_cmd(w_fcmd),
        .i_pop(w_pop), .o_full(w_full), .o_empty(w_empty), .o_cmd(w_qcmd)
    );

    // back: memory work and the result strobe
    tbt_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_q_empty(w_empty), .i_cmd(w_qcmd),
        .o_pop(w_pop), .o_idle(w_back_idle),
        .o_done(o_done), .o_rsp(o_rsp)
    );

    // one item in flight at a time
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else begin
            if (i_start && !o_busy) r_pend <= 1'b1;
            else if (o_done) r_pend <= 1'b0;
        end
    end
    assign o_busy = w_fbusy || r_pend;
endmodule
`default_nettype wire

// ===== src/tbt_checker.sv =====
// port checker for the token bucket table and its bind
`default_nettype none
`include "assert_macros.svh"
module tbt_checker (
    input wire logic          i_clk,
    input wire logic          i_rst_n,
    input wire logic          i_start,
    input wire logic          o_busy,
    input wire logic          o_done,
    input wire tbt_pkg::t_rsp o_rsp
);
    `AST_NXT(a_acc_busy, i_clk, i_rst_n, i_start && !o_busy, o_busy)
    `AST_IMP(a_done_busy, i_clk, i_rst_n, o_done, o_busy)
    `AST_NXT(a_done_once, i_clk, i_rst_n, o_done, !o_done)
    `AST_IMP(a_status_rng, i_clk, i_rst_n, o_done, o_rsp.status <= tbt_pkg::ST_EMPTY)
endmodule
bind token_bucket_table tbt_checker u_chk (.*);
`default_nettype wire
